// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; files that check take this in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on each clock edge outside reset.
`define SBMC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sbmc assertion failed");
// Check a property on each clock edge, reset included.
`define SBMC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sbmc assertion failed");
`else
`define SBMC_ASSERT(label, clk, rst, prop)
`define SBMC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== sv/sbmc_pkg.sv =====
// Types and constants of the servo balance mode controller.
// No dependencies; used by sbmc_servo_step and the top level.
package sbmc_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS  = 8;
  localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN       = 2 * HALF_TURN;

  // Operation codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ON        = 3'd1;
  localparam logic [2:0] OP_OFF       = 3'd2;
  localparam logic [2:0] OP_REF_START = 3'd3;
  localparam logic [2:0] OP_REF_STOP  = 3'd4;

  // Mode codes
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_REF = 2'd1;
  localparam logic [1:0] MODE_BAL = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_GAIN          = 3'd0;
  localparam logic [2:0] CFG_GAIN_NEGATIVE = 3'd1;
  localparam logic [2:0] CFG_DEADBAND      = 3'd2;
  localparam logic [2:0] CFG_CENTER        = 3'd3;
  localparam logic [2:0] CFG_MIN_SAFE      = 3'd4;
  localparam logic [2:0] CFG_MAX_SAFE      = 3'd5;
  localparam logic [2:0] CFG_MAX_STEP      = 3'd6;

  // Reset values
  localparam logic [11:0] GAIN_RST     = 12'd384;
  localparam logic [15:0] DEADBAND_RST = 16'(((7 << ANGLE_FRAC_BITS) / 10) & 16'hffff);
  localparam logic [15:0] CENTER_RST   = 16'((90 << ANGLE_FRAC_BITS) & 16'hffff);
  localparam logic [15:0] MIN_SAFE_RST = 16'((20 << ANGLE_FRAC_BITS) & 16'hffff);
  localparam logic [15:0] MAX_SAFE_RST = 16'((160 << ANGLE_FRAC_BITS) & 16'hffff);
  localparam logic [15:0] MAX_STEP_RST = 16'((1 << ANGLE_FRAC_BITS) & 16'hffff);

  typedef struct packed {
    logic [11:0] gain;
    logic        gain_negative;
    logic [15:0] deadband;
    logic [15:0] center_angle;
    logic [15:0] min_safe_angle;
    logic [15:0] max_safe_angle;
    logic [15:0] max_step;
  } cfg_t;

endpackage

// ===== sv/servo_balance_mode_controller_core.sv =====
// Servo balance mode controller: mode machine plus proportional servo loop.
// An item passes from input transfer to result transfer through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the servo step is one pass of logic between the two.
// Reset (rst, synchronous): mode off, LED off, no blink, reference 0,
// servo position at the center reset value, configuration at its reset values.
module servo_balance_mode_controller_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [16:0] pitch_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        servo_cmd,
  output logic               servo_update,
  output logic [1:0]         mode,
  output logic               led_on,
  output logic               led_blink,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sbmc_pkg::*;
`include "assert_macros.svh"

  cfg_t               cfg;
  logic               s1_valid;
  logic [2:0]         s1_op;
  logic signed [16:0] s1_pitch;
  logic               s1_adv;

  logic [1:0]         mode_reg;
  logic               blinking;
  logic signed [17:0] reference_angle;
  logic [15:0]        servo_position;
  logic               led_level;

  logic [1:0]         mode_next;
  logic               blinking_next;
  logic signed [17:0] reference_next;
  logic [15:0]        position_next;
  logic               led_next;
  logic [15:0]        angle_next;
  logic               update_next;
  logic [15:0]        step_position;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain           <= GAIN_RST;
      cfg.gain_negative  <= 1'b0;
      cfg.deadband       <= DEADBAND_RST;
      cfg.center_angle   <= CENTER_RST;
      cfg.min_safe_angle <= MIN_SAFE_RST;
      cfg.max_safe_angle <= MAX_SAFE_RST;
      cfg.max_step       <= MAX_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN:          cfg.gain           <= cfg_data[11:0];
        CFG_GAIN_NEGATIVE: cfg.gain_negative  <= cfg_data[0];
        CFG_DEADBAND:      cfg.deadband       <= cfg_data;
        CFG_CENTER:        cfg.center_angle   <= cfg_data;
        CFG_MIN_SAFE:      cfg.min_safe_angle <= cfg_data;
        CFG_MAX_SAFE:      cfg.max_safe_angle <= cfg_data;
        CFG_MAX_STEP:      cfg.max_step       <= cfg_data;
        default: ;
      endcase
    end
  end

  sbmc_servo_step u_step (
    .cfg             (cfg),
    .reference_angle (reference_angle),
    .pitch_angle     (s1_pitch),
    .position        (servo_position),
    .position_next   (step_position)
  );

  always_comb begin
    mode_next      = mode_reg;
    blinking_next  = blinking;
    reference_next = reference_angle;
    position_next  = servo_position;
    led_next       = led_level;
    angle_next     = servo_position;
    update_next    = 1'b0;
    case (s1_op)
      OP_TICK: begin
        if (mode_reg == MODE_BAL) begin
          position_next = step_position;
          angle_next    = step_position;
          update_next   = 1'b1;
        end
      end
      OP_ON: begin
        mode_next = MODE_REF;
        led_next  = 1'b1;
      end
      OP_OFF: begin
        mode_next   = MODE_OFF;
        led_next    = 1'b0;
        angle_next  = cfg.center_angle;
        update_next = 1'b1;
      end
      OP_REF_START: begin
        blinking_next = 1'b1;
      end
      OP_REF_STOP: begin
        if (blinking) begin
          blinking_next  = 1'b0;
          led_next       = 1'b1;
          mode_next      = MODE_BAL;
          reference_next = 18'(s1_pitch);
        end
      end
      default: ;
    endcase
  end

  // input register, controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      mode_reg        <= MODE_OFF;
      blinking        <= 1'b0;
      reference_angle <= '0;
      servo_position  <= CENTER_RST;
      led_level       <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid       <= 1'b1;
        mode_reg        <= mode_next;
        blinking        <= blinking_next;
        reference_angle <= reference_next;
        servo_position  <= position_next;
        led_level       <= led_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op    <= operation;
      s1_pitch <= pitch_angle;
    end
    if (s1_adv) begin
      servo_cmd    <= angle_next;
      servo_update <= update_next;
      mode         <= mode_next;
      led_on       <= led_next;
      led_blink    <= (mode_next == MODE_REF) && blinking_next;
    end
  end

  `SBMC_ASSERT(a_blink_only_in_ref, clk, rst, out_valid && led_blink |-> mode == MODE_REF)
  `SBMC_ASSERT(a_bal_update_tracks, clk, rst, out_valid && servo_update && mode == MODE_BAL |-> servo_cmd == servo_position)
  `SBMC_ASSERT(a_off_sends_center, clk, rst, out_valid && servo_update && mode == MODE_OFF |-> servo_cmd == cfg.center_angle)

endmodule

// ===== sv/sbmc_servo_step.sv =====
// One proportional servo step: wrap, deadband, gain, clamp and slew limit.
// Depends on sbmc_pkg for cfg_t and the angle constants.
module sbmc_servo_step (
  input  sbmc_pkg::cfg_t      cfg,
  input  logic signed [17:0]  reference_angle,
  input  logic signed [16:0]  pitch_angle,
  input  logic        [15:0]  position,
  output logic        [15:0]  position_next
);
  import sbmc_pkg::*;

  logic signed [18:0] err_raw;
  logic signed [18:0] err_wrap;
  logic               err_neg;
  logic        [16:0] err_mag;
  logic        [16:0] mag_db;
  logic        [28:0] prod_full;
  logic        [20:0] prod;
  logic               dir_neg;
  logic signed [22:0] target_raw;
  logic        [15:0] target;
  logic signed [17:0] diff;
  logic signed [17:0] step_s;

  always_comb begin
    err_raw = 19'(reference_angle) - 19'(pitch_angle);
    // one turn of correction always suffices for the input range
    if (err_raw > $signed(19'(HALF_TURN))) begin
      err_wrap = err_raw - $signed(19'(FULL_TURN));
    end else if (err_raw < -$signed(19'(HALF_TURN))) begin
      err_wrap = err_raw + $signed(19'(FULL_TURN));
    end else begin
      err_wrap = err_raw;
    end

    err_neg = err_wrap[18];
    err_mag = err_neg ? 17'(-err_wrap) : 17'(err_wrap);
    mag_db  = (err_mag < {1'b0, cfg.deadband}) ? 17'd0 : err_mag;

    // round half away from zero on the magnitude
    prod_full = 29'(mag_db) * 29'(cfg.gain) + 29'(1 << (GAIN_FRAC_BITS - 1));
    prod      = prod_full[28:GAIN_FRAC_BITS];
    dir_neg   = (err_neg && (mag_db != 17'd0)) ^ cfg.gain_negative;

    target_raw = dir_neg ? $signed(23'(cfg.center_angle)) - $signed(23'(prod))
                         : $signed(23'(cfg.center_angle)) + $signed(23'(prod));

    if (target_raw < $signed(23'(cfg.min_safe_angle))) begin
      target = cfg.min_safe_angle;
    end else if (target_raw > $signed(23'(cfg.max_safe_angle))) begin
      target = cfg.max_safe_angle;
    end else begin
      target = target_raw[15:0];
    end

    diff   = $signed(18'(target)) - $signed(18'(position));
    step_s = $signed(18'(cfg.max_step));
    if (diff > step_s) begin
      position_next = 16'(18'(position) + 18'(cfg.max_step));
    end else if (diff < -step_s) begin
      position_next = 16'(18'(position) - 18'(cfg.max_step));
    end else begin
      position_next = target;
    end
  end

endmodule
